// ===== rtl/core/cwu_pkg.sv =====
// Shared types and constants for the congestion window update block.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package cwu_pkg;

  // Event kinds carried in the func field
  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_SEGMENT = 2'd1;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SEGMENT_SIZE      = 2'd0;
  localparam logic [1:0] CFG_INITIAL_WINDOW    = 2'd1;
  localparam logic [1:0] CFG_INITIAL_THRESHOLD = 2'd2;

  // Configuration reset values
  localparam logic [15:0] SEGMENT_SIZE_RST      = 16'd1460;
  localparam logic [31:0] INITIAL_WINDOW_RST    = 32'd4380;
  localparam logic [31:0] INITIAL_THRESHOLD_RST = 32'd65535;

  // Duplicate count at which the next repeated ACK starts fast recovery
  localparam logic [7:0] DUP_THRESHOLD = 8'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic        is_ack;
    logic [31:0] ack_value;
    logic [15:0] advertised_window;
    logic [31:0] start_sequence;
  } evt_t;

  typedef struct packed {
    logic [31:0] congestion_window;
    logic [31:0] slow_start_threshold;
    logic [31:0] next_sequence;
    logic [15:0] peer_window_now;
    logic        resend_request;
    logic [31:0] resend_byte_count;
    logic        window_probe;
    logic [7:0]  duplicate_count;
  } res_t;

  typedef struct packed {
    logic [15:0] segment_size;
    logic [31:0] initial_window;
    logic [31:0] initial_threshold;
  } cfg_t;

  typedef struct packed {
    logic [31:0] cwnd;
    logic [31:0] ssthresh;
    logic [31:0] send_sequence;
    logic [15:0] peer_window;
    logic [31:0] last_advanced_ack;
    logic [7:0]  dup_counter;
    logic [31:0] last_received_ack;
    logic [15:0] last_received_window;
  } state_t;

endpackage

// ===== rtl/core/cwu_evt_if.sv =====
// Event channel: valid/ready handshake carrying one event word.
// Depends on cwu_pkg for the payload type.
`timescale 1ns / 1ps

interface cwu_evt_if;
  logic          valid;
  logic          ready;
  cwu_pkg::evt_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/cwu_res_if.sv =====
// Result channel: valid/ready handshake carrying one result word.
// Depends on cwu_pkg for the payload type.
`timescale 1ns / 1ps

interface cwu_res_if;
  logic          valid;
  logic          ready;
  cwu_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/cwu_update.sv =====
// Next-state and result logic for one event: Reno window rules.
// Depends on cwu_pkg for event, state, configuration and result types.
`timescale 1ns / 1ps

module cwu_update (
  input  cwu_pkg::cfg_t   cfg,
  input  cwu_pkg::state_t st,
  input  cwu_pkg::evt_t   evt,
  output cwu_pkg::state_t st_next,
  output cwu_pkg::res_t   res_next
);

  logic        advance;
  logic        fast_rec;
  logic [32:0] seq_span;
  logic        dup_hit;
  logic [31:0] half_cwnd;
  logic [31:0] grow_base;
  logic [31:0] grow_add;
  logic        grow_slow;
  logic [31:0] grow_step;
  logic [33:0] grow_sum;
  logic [31:0] grown;
  logic [31:0] fr_lost;
  logic [31:0] to_lost;

  assign advance   = evt.ack_value > st.send_sequence;
  assign fast_rec  = !advance && (st.dup_counter >= cwu_pkg::DUP_THRESHOLD);
  assign seq_span  = {1'b0, st.send_sequence} + {17'd0, cfg.segment_size};
  assign dup_hit   = !advance && !fast_rec && ({1'b0, evt.ack_value} <= seq_span) &&
                     (st.last_advanced_ack == evt.ack_value);
  assign half_cwnd = {1'b0, st.cwnd[31:1]};

  // Fold the fast recovery reload and the growth step into one add. After
  // the reload cwnd sits at or below ssthresh only when initial_window is 0.
  assign grow_base = fast_rec ? half_cwnd : st.cwnd;
  assign grow_add  = fast_rec ? cfg.initial_window : 32'd0;
  assign grow_slow = fast_rec ? (cfg.initial_window == 32'd0) : (st.cwnd <= st.ssthresh);
  assign grow_step = grow_slow ? {16'd0, cfg.segment_size} : 32'd1;
  assign grow_sum  = {2'b00, grow_base} + {2'b00, grow_add} + {2'b00, grow_step};
  assign grown     = (grow_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : grow_sum[31:0];

  // Fast recovery only runs when the ACK does not pass send_sequence
  assign fr_lost = st.send_sequence - evt.ack_value;
  assign to_lost = (st.send_sequence >= st.last_received_ack) ?
                   (st.send_sequence - st.last_received_ack) : 32'd0;

  always_comb begin
    st_next                    = st;
    res_next.resend_request    = 1'b0;
    res_next.resend_byte_count = 32'd0;
    res_next.window_probe      = 1'b0;
    case (evt.func)
      cwu_pkg::FUNC_START: begin
        st_next.cwnd                 = cfg.initial_window;
        st_next.ssthresh             = cfg.initial_threshold;
        st_next.send_sequence        = evt.start_sequence;
        st_next.peer_window          = 16'd0;
        st_next.last_advanced_ack    = 32'd0;
        st_next.dup_counter          = 8'd0;
        st_next.last_received_ack    = 32'd0;
        st_next.last_received_window = 16'd0;
      end
      cwu_pkg::FUNC_SEGMENT: begin
        st_next.last_received_ack    = evt.ack_value;
        st_next.last_received_window = evt.advertised_window;
        if (evt.is_ack) begin
          if (advance) begin
            st_next.send_sequence     = evt.ack_value;
            st_next.peer_window       = evt.advertised_window;
            st_next.last_advanced_ack = evt.ack_value;
            st_next.dup_counter       = 8'd0;
          end else if (fast_rec) begin
            st_next.ssthresh           = half_cwnd;
            st_next.send_sequence      = evt.ack_value;
            st_next.peer_window        = evt.advertised_window;
            res_next.resend_request    = 1'b1;
            res_next.resend_byte_count = fr_lost;
          end else if (dup_hit) begin
            st_next.dup_counter = st.dup_counter + 8'd1;
          end
          st_next.cwnd          = grown;
          res_next.window_probe = (st_next.peer_window == 16'd0);
        end
      end
      cwu_pkg::FUNC_TIMEOUT: begin
        st_next.ssthresh           = half_cwnd;
        st_next.cwnd               = {16'd0, cfg.segment_size};
        st_next.send_sequence      = st.last_received_ack;
        st_next.peer_window        = st.last_received_window;
        res_next.resend_request    = 1'b1;
        res_next.resend_byte_count = to_lost;
      end
      default: begin
        st_next = st;
      end
    endcase
    res_next.congestion_window    = st_next.cwnd;
    res_next.slow_start_threshold = st_next.ssthresh;
    res_next.next_sequence        = st_next.send_sequence;
    res_next.peer_window_now      = st_next.peer_window;
    res_next.duplicate_count      = st_next.dup_counter;
  end

endmodule

// ===== rtl/core/tcp_congestion_window_update_top.sv =====
// Top level of the Reno-style congestion window update block.
// Depends on cwu_pkg, cwu_evt_if, cwu_res_if and cwu_update.
`timescale 1ns / 1ps

// Usage
// - evt: one word per event (connection start, segment received, timeout),
//   taken at a clock edge where evt.valid and evt.ready are both high.
// - res: one result word per event, in event order, handed over when
//   res.valid and res.ready are both high.
// - cfg_we/cfg_index/cfg_data: register writes (0 segment size, 1 initial
//   window, 2 initial threshold); change them only while no event is in flight.
// Timing
// - Path: a taken word sits in the input stage, then in the result register.
// - Throughput: one event per cycle while res.ready stays high. The window
//   state lives in one set of registers that the update logic reads and
//   rewrites as each event retires, so consecutive events chain without bubbles.
// Reset (rst, synchronous): configuration returns to 1460 / 4380 / 65535,
//   cwnd to 4380, ssthresh to 65535, the rest of the state to zero, and both
//   the input stage and the result register empty.
// Stall: when res.ready is low the result register holds its word, the input
//   stage takes one more word, and then evt.ready drops until res drains.

module tcp_congestion_window_update_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  cwu_evt_if.sink          evt,
  cwu_res_if.source        res
);

  cwu_pkg::cfg_t   cfg;
  cwu_pkg::state_t st;
  cwu_pkg::state_t st_next;
  cwu_pkg::res_t   res_next;
  cwu_pkg::evt_t   in_word;
  cwu_pkg::res_t   out_word;
  logic            in_full;
  logic            out_full;
  logic            advance;

  // Move the held event into the result register when it has room
  assign advance   = in_full && (!out_full || res.ready);
  assign evt.ready = !in_full || advance;
  assign res.valid = out_full;
  assign res.data  = out_word;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.segment_size      <= cwu_pkg::SEGMENT_SIZE_RST;
      cfg.initial_window    <= cwu_pkg::INITIAL_WINDOW_RST;
      cfg.initial_threshold <= cwu_pkg::INITIAL_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cwu_pkg::CFG_SEGMENT_SIZE:      cfg.segment_size      <= cfg_data[15:0];
        cwu_pkg::CFG_INITIAL_WINDOW:    cfg.initial_window    <= cfg_data;
        cwu_pkg::CFG_INITIAL_THRESHOLD: cfg.initial_threshold <= cfg_data;
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // Input stage: hold one event word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (evt.ready) begin
      in_full <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      in_word <= evt.data;
    end
  end

  cwu_update u_update (
    .cfg      (cfg),
    .st       (st),
    .evt      (in_word),
    .st_next  (st_next),
    .res_next (res_next)
  );

  // Connection state: rewritten exactly when an event retires into res
  always_ff @(posedge clk) begin
    if (rst) begin
      st.cwnd                 <= cwu_pkg::INITIAL_WINDOW_RST;
      st.ssthresh             <= cwu_pkg::INITIAL_THRESHOLD_RST;
      st.send_sequence        <= 32'd0;
      st.peer_window          <= 16'd0;
      st.last_advanced_ack    <= 32'd0;
      st.dup_counter          <= 8'd0;
      st.last_received_ack    <= 32'd0;
      st.last_received_window <= 16'd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (res.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= res_next;
    end
  end

  // A pending result always mirrors the live window state
  a_res_tracks_state: assert property (@(posedge clk) disable iff (rst)
    out_full |-> (out_word.congestion_window == st.cwnd) &&
                 (out_word.next_sequence == st.send_sequence) &&
                 (out_word.duplicate_count == st.dup_counter))
    else $error("result word out of step with window state");

  // Fast recovery fires at three duplicates, so the count never passes three
  a_dup_bounded: assert property (@(posedge clk) disable iff (rst)
    st.dup_counter <= cwu_pkg::DUP_THRESHOLD)
    else $error("duplicate count above fast recovery threshold");

  a_no_stray_resend: assert property (@(posedge clk) disable iff (rst)
    out_full && !out_word.resend_request |-> out_word.resend_byte_count == 32'd0)
    else $error("resend byte count without resend request");

  a_probe_zero_window: assert property (@(posedge clk) disable iff (rst)
    out_full && out_word.window_probe |-> out_word.peer_window_now == 16'd0)
    else $error("window probe with open peer window");

  // State moves only when an event retires
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("window state changed without a retiring event");

endmodule
